>>> hw/rtl/quad_channel_quadrature_decoder_assert.svh
// assertion macros shared by the quadrature decoder rtl
`ifndef QUAD_CHANNEL_QUADRATURE_DECODER_ASSERT_SVH
`define QUAD_CHANNEL_QUADRATURE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define QCQD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// clocked check that also holds through reset
`define QCQD_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define QCQD_ASSERT(name, prop, msg)
`define QCQD_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

>>> hw/rtl/qcqd_pkg.sv
// types, constants and helper functions of the quadrature decoder
`timescale 1ns / 1ps
package qcqd_pkg;

	// structural constants
	localparam int MAX_CHANNELS = 4;
	localparam int COUNT_WIDTH  = 32;
	localparam int NUM_OUT_CH   = 4;
	localparam int OUT_COUNT_W  = 32;
	localparam int PHASE_W      = 2;
	localparam int SAMPLE_W     = 8;
	localparam int OP_W         = 2;
	localparam int CHAN_W       = 2;
	localparam int PRESET_W     = 32;
	localparam int CODE_W       = 2 * PHASE_W;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 3;
	localparam int CHCNT_W     = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_MODE    = 1'd1;
	localparam logic [CHCNT_W-1:0]     CHCNT_RESET       = 3'd4;

	// channel count clamp: at most four and at most the lanes built
	localparam int ACTIVE_LIMIT = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_UPDATE  = 2'd0,
		OP_CAPTURE = 2'd1,
		OP_PRESET  = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// transition codes, old phase in the high bits
	localparam logic [CODE_W-1:0] CODE_UP_A   = 4'b0001;
	localparam logic [CODE_W-1:0] CODE_UP_B   = 4'b0111;
	localparam logic [CODE_W-1:0] CODE_UP_C   = 4'b1110;
	localparam logic [CODE_W-1:0] CODE_UP_D   = 4'b1000;
	localparam logic [CODE_W-1:0] CODE_DN_A   = 4'b0010;
	localparam logic [CODE_W-1:0] CODE_DN_B   = 4'b0100;
	localparam logic [CODE_W-1:0] CODE_DN_C   = 4'b1101;
	localparam logic [CODE_W-1:0] CODE_DN_D   = 4'b1011;
	localparam logic [CODE_W-1:0] CODE_JMP_A  = 4'b0011;
	localparam logic [CODE_W-1:0] CODE_JMP_B  = 4'b0110;
	localparam logic [CODE_W-1:0] CODE_JMP_C  = 4'b1001;
	localparam logic [CODE_W-1:0] CODE_JMP_D  = 4'b1100;

	// per-lane control from the decoder
	typedef struct packed {
		logic take;
		logic update;
		logic capture;
		logic preset;
		logic single;
	} lane_ctrl_t;

	// one result item
	typedef struct packed {
		logic                                  changed;
		logic [NUM_OUT_CH-1:0][OUT_COUNT_W-1:0] count;
		logic [NUM_OUT_CH-1:0][PHASE_W-1:0]     phase;
	} result_t;

	// counter increment for one transition code
	function automatic logic [COUNT_WIDTH-1:0] step_amount(
		input logic [CODE_W-1:0] code,
		input logic              single
	);
		logic [COUNT_WIDTH-1:0] amt;
		amt = '0;
		case (code) inside
			CODE_UP_A, CODE_UP_B, CODE_UP_C, CODE_UP_D:
				amt = COUNT_WIDTH'(1);
			CODE_DN_A, CODE_DN_B, CODE_DN_C, CODE_DN_D:
				amt = single ? COUNT_WIDTH'(3) : '1;
			CODE_JMP_A, CODE_JMP_B, CODE_JMP_C, CODE_JMP_D:
				amt = single ? COUNT_WIDTH'(2) : '0;
			default:
				amt = '0;
		endcase
		return amt;
	endfunction

	// preset value sign-extended or cut to the counter width
	function automatic logic [COUNT_WIDTH-1:0] sext_preset(
		input logic signed [PRESET_W-1:0] val
	);
		return COUNT_WIDTH'(val);
	endfunction

endpackage

>>> hw/rtl/qcqd_in_if.sv
// sample channel interface
`timescale 1ns / 1ps
interface qcqd_in_if;
	logic                                    valid;
	logic                                    ready;
	logic [qcqd_pkg::OP_W-1:0]               operation;
	logic [qcqd_pkg::SAMPLE_W-1:0]           pin_sample;
	logic [qcqd_pkg::CHAN_W-1:0]             channel;
	logic signed [qcqd_pkg::PRESET_W-1:0]    preset_value;

	modport source (output valid, operation, pin_sample, channel, preset_value, input ready);
	modport sink (input valid, operation, pin_sample, channel, preset_value, output ready);
endinterface

>>> hw/rtl/qcqd_out_if.sv
// result channel interface
`timescale 1ns / 1ps
interface qcqd_out_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    changed;
	logic signed [qcqd_pkg::OUT_COUNT_W-1:0] count_0;
	logic signed [qcqd_pkg::OUT_COUNT_W-1:0] count_1;
	logic signed [qcqd_pkg::OUT_COUNT_W-1:0] count_2;
	logic signed [qcqd_pkg::OUT_COUNT_W-1:0] count_3;
	logic [qcqd_pkg::PHASE_W-1:0]            phase_0;
	logic [qcqd_pkg::PHASE_W-1:0]            phase_1;
	logic [qcqd_pkg::PHASE_W-1:0]            phase_2;
	logic [qcqd_pkg::PHASE_W-1:0]            phase_3;

	modport source (output valid, changed, count_0, count_1, count_2, count_3,
		phase_0, phase_1, phase_2, phase_3, input ready);
	modport sink (input valid, changed, count_0, count_1, count_2, count_3,
		phase_0, phase_1, phase_2, phase_3, output ready);
endinterface

>>> hw/rtl/qcqd_cfg_if.sv
// configuration write channel interface
`timescale 1ns / 1ps
interface qcqd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [qcqd_pkg::CFG_INDEX_W-1:0]   reg_index;
	logic [qcqd_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, reg_index, data, input ready);
	modport sink (input valid, reg_index, data, output ready);
endinterface

>>> hw/rtl/quad_channel_quadrature_decoder.sv
// Four-channel x4 quadrature decoder. Takes one item per clock on samp while
// samp.ready is high and returns one result per item on res, driven from the
// output register. Each channel has its own lane holding phase and 32-bit
// counter; every lane steps in the same cycle, so throughput is one item per
// clock as long as results are taken. An output register backed by one skid
// entry decouples the two sides: samp.ready drops only when two results wait
// untaken. Configuration writes complete at once (cfg.ready is always high)
// and must only be issued while the block is idle. No clearing pass follows
// reset; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
module quad_channel_quadrature_decoder (
	input  logic       clk,
	input  logic       arst_n,
	qcqd_in_if.sink    samp,
	qcqd_out_if.source res,
	qcqd_cfg_if.sink   cfg
);

	logic [qcqd_pkg::CHCNT_W-1:0]  channel_count_q;
	logic                          count_mode_q;
	logic [qcqd_pkg::SAMPLE_W-1:0] last_sample_q;
	logic [qcqd_pkg::CHCNT_W-1:0]  active_n;
	logic                          take;
	logic                          in_ready;
	logic                          is_update;
	logic                          is_capture;
	logic                          is_preset;
	logic                          changed;
	logic [qcqd_pkg::COUNT_WIDTH-1:0] preset_val;
	logic [qcqd_pkg::MAX_CHANNELS-1:0][qcqd_pkg::COUNT_WIDTH-1:0] lane_count;
	logic [qcqd_pkg::MAX_CHANNELS-1:0][qcqd_pkg::PHASE_W-1:0]     lane_phase;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= qcqd_pkg::CHCNT_RESET;
			count_mode_q    <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				qcqd_pkg::REG_CHANNEL_COUNT: begin
					channel_count_q <= qcqd_pkg::CHCNT_W'(cfg.data);
				end
				qcqd_pkg::REG_COUNT_MODE: begin
					count_mode_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// active channel clamp
	assign active_n = (channel_count_q > qcqd_pkg::CHCNT_W'(qcqd_pkg::ACTIVE_LIMIT))
		? qcqd_pkg::CHCNT_W'(qcqd_pkg::ACTIVE_LIMIT) : channel_count_q;

	// operation decode
	always_comb begin
		is_update  = 1'b0;
		is_capture = 1'b0;
		is_preset  = 1'b0;
		unique case (qcqd_pkg::op_t'(samp.operation))
			qcqd_pkg::OP_UPDATE:  is_update  = 1'b1;
			qcqd_pkg::OP_CAPTURE: is_capture = 1'b1;
			qcqd_pkg::OP_PRESET:  is_preset  = 1'b1;
			default: begin
			end
		endcase
	end

	assign take       = samp.valid && in_ready;
	assign samp.ready = in_ready;
	assign changed    = is_update && (samp.pin_sample != last_sample_q);
	assign preset_val = qcqd_pkg::sext_preset(samp.preset_value);

	// last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
		end else if (take && (changed || is_capture)) begin
			last_sample_q <= samp.pin_sample;
		end
	end

	// channel lanes
	for (genvar i = 0; i < qcqd_pkg::MAX_CHANNELS; i++) begin : g_lane
		qcqd_pkg::lane_ctrl_t ctrl;
		logic                 active;

		assign active       = qcqd_pkg::CHCNT_W'(i) < active_n;
		assign ctrl.take    = take;
		assign ctrl.update  = changed && active;
		assign ctrl.capture = is_capture && active;
		assign ctrl.preset  = is_preset && (samp.channel == qcqd_pkg::CHAN_W'(i));
		assign ctrl.single  = count_mode_q;

		qcqd_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_phase  (samp.pin_sample[qcqd_pkg::PHASE_W*i +: qcqd_pkg::PHASE_W]),
			.preset_val (preset_val),
			.count_next (lane_count[i]),
			.phase_next (lane_phase[i])
		);
	end

	// result merge and output buffering
	qcqd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.changed    (changed),
		.lane_count (lane_count),
		.lane_phase (lane_phase),
		.in_ready   (in_ready),
		.res        (res)
	);

endmodule

>>> hw/rtl/qcqd_lane.sv
// one decoder lane: stored phase, position counter and step logic
`timescale 1ns / 1ps
`include "quad_channel_quadrature_decoder_assert.svh"
module qcqd_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qcqd_pkg::lane_ctrl_t                 ctrl,
	input  logic [qcqd_pkg::PHASE_W-1:0]         new_phase,
	input  logic [qcqd_pkg::COUNT_WIDTH-1:0]     preset_val,
	output logic [qcqd_pkg::COUNT_WIDTH-1:0]     count_next,
	output logic [qcqd_pkg::PHASE_W-1:0]         phase_next
);

	logic [qcqd_pkg::COUNT_WIDTH-1:0] count_q;
	logic [qcqd_pkg::PHASE_W-1:0]     phase_q;
	logic [qcqd_pkg::CODE_W-1:0]      code;
	logic [qcqd_pkg::COUNT_WIDTH-1:0] step;

	// transition code and increment
	assign code = {phase_q, new_phase};
	assign step = qcqd_pkg::step_amount(code, ctrl.single);

	// next lane state
	always_comb begin
		count_next = count_q;
		if (ctrl.preset) begin
			count_next = preset_val;
		end else if (ctrl.update) begin
			count_next = count_q + step;
		end
		phase_next = (ctrl.update || ctrl.capture) ? new_phase : phase_q;
	end

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
		end else if (ctrl.take) begin
			count_q <= count_next;
			phase_q <= phase_next;
		end
	end

	`QCQD_ASSERT(a_lane_hold, !ctrl.take |=> $stable(count_q) && $stable(phase_q), "lane state moved without a transfer")
	`QCQD_ASSERT(a_capture_keeps_count, ctrl.take && ctrl.capture |=> $stable(count_q), "capture altered a counter")

endmodule

>>> hw/rtl/qcqd_merge.sv
// merges lane results into the result item, output register plus skid entry
`timescale 1ns / 1ps
`include "quad_channel_quadrature_decoder_assert.svh"
module qcqd_merge (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    take,
	input  logic                                                    changed,
	input  logic [qcqd_pkg::MAX_CHANNELS-1:0][qcqd_pkg::COUNT_WIDTH-1:0] lane_count,
	input  logic [qcqd_pkg::MAX_CHANNELS-1:0][qcqd_pkg::PHASE_W-1:0]     lane_phase,
	output logic                                                    in_ready,
	qcqd_out_if.source                                              res
);

	qcqd_pkg::result_t next_res;
	qcqd_pkg::result_t out_q;
	qcqd_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              out_take;
	logic              out_free;

	// gather lanes, channels without a lane read zero
	assign next_res.changed = changed;
	for (genvar i = 0; i < qcqd_pkg::NUM_OUT_CH; i++) begin : g_gather
		if (i < qcqd_pkg::MAX_CHANNELS) begin : g_lane
			assign next_res.count[i] = qcqd_pkg::OUT_COUNT_W'(lane_count[i]);
			assign next_res.phase[i] = lane_phase[i];
		end else begin : g_none
			assign next_res.count[i] = '0;
			assign next_res.phase[i] = '0;
		end
	end

	// handshake
	assign out_take = out_valid_q && res.ready;
	assign out_free = out_take || !out_valid_q;
	assign in_ready = !skid_valid_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= next_res;
			end
		end else if (take) begin
			skid_q <= next_res;
		end
	end

	// drive result channel
	assign res.valid   = out_valid_q;
	assign res.changed = out_q.changed;
	assign res.count_0 = $signed(out_q.count[0]);
	assign res.count_1 = $signed(out_q.count[1]);
	assign res.count_2 = $signed(out_q.count[2]);
	assign res.count_3 = $signed(out_q.count[3]);
	assign res.phase_0 = out_q.phase[0];
	assign res.phase_1 = out_q.phase[1];
	assign res.phase_2 = out_q.phase[2];
	assign res.phase_3 = out_q.phase[3];

	`QCQD_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry full with empty output register")
	`QCQD_ASSERT(a_stall_fills_skid, take && out_valid_q && !res.ready |=> skid_valid_q, "stalled transfer not parked in skid")
	`QCQD_ASSERT(a_skid_drains, out_take && skid_valid_q |=> out_valid_q && !skid_valid_q, "skid entry not moved to output")

endmodule

>>> bench/quad_channel_quadrature_decoder_tb.sv
// self-checking testbench for the four-channel quadrature decoder
`timescale 1ns / 1ps
module quad_channel_quadrature_decoder_tb;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int NUM_PHASES      = 9;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int PRESSURE_PHASE  = 6;
	localparam int HOLD_CYCLES     = 60;

	// register settings walked by the random phases, extremes included
	localparam logic [qcqd_pkg::CHCNT_W-1:0] PHASE_CHANNELS [0:NUM_PHASES-1] =
		'{3'd4, 3'd0, 3'd7, 3'd1, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};
	localparam bit PHASE_SINGLE [0:NUM_PHASES-1] =
		'{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	// preset values next to the counter wrap points
	localparam logic [31:0] WRAP_VALUES [0:3] =
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};

	// one sample channel item, with an optional hand-written expectation
	typedef struct {
		qcqd_pkg::op_t       op;
		logic [7:0]          sample;
		logic [1:0]          chan;
		logic signed [31:0]  preset;
		bit                  typed;
		qcqd_pkg::result_t   want;
	} stim_t;

	logic clk;
	logic arst_n;

	qcqd_in_if  samp_if ();
	qcqd_out_if res_if ();
	qcqd_cfg_if cfg_if ();

	quad_channel_quadrature_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.samp   (samp_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// decoder state as the bench expects it
	logic [qcqd_pkg::CHCNT_W-1:0] cfg_channels;
	logic                         cfg_single;
	logic [7:0]                   model_sample;
	logic [1:0]                   model_phase [0:3];
	logic [31:0]                  model_count [0:3];

	qcqd_pkg::result_t pending_results [$];
	stim_t             directed_rows [$];

	int mismatch_count;
	int items_sent;
	int results_seen;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag_error(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// counter change for one transition code, old phase in the high bits
	function automatic logic [31:0] move_delta(input logic [3:0] code, input logic single);
		case (code) inside
			qcqd_pkg::CODE_UP_A, qcqd_pkg::CODE_UP_B,
			qcqd_pkg::CODE_UP_C, qcqd_pkg::CODE_UP_D:
				return 32'd1;
			qcqd_pkg::CODE_DN_A, qcqd_pkg::CODE_DN_B,
			qcqd_pkg::CODE_DN_C, qcqd_pkg::CODE_DN_D:
				return single ? 32'd3 : 32'hFFFF_FFFF;
			qcqd_pkg::CODE_JMP_A, qcqd_pkg::CODE_JMP_B,
			qcqd_pkg::CODE_JMP_C, qcqd_pkg::CODE_JMP_D:
				return single ? 32'd2 : 32'd0;
			default:
				return 32'd0;
		endcase
	endfunction

	function automatic int active_lanes();
		return (cfg_channels > 3'd4) ? 4 : int'(cfg_channels);
	endfunction

	// advance the expected decoder state by one item and return its result
	function automatic qcqd_pkg::result_t decoder_step(input stim_t s);
		qcqd_pkg::result_t r;
		logic [1:0] cur;
		int n;
		r = '0;
		n = active_lanes();
		case (s.op)
			qcqd_pkg::OP_UPDATE: begin
				if (s.sample != model_sample) begin
					r.changed = 1'b1;
					model_sample = s.sample;
					for (int i = 0; i < n; i++) begin
						cur = s.sample[2*i +: 2];
						model_count[i] = model_count[i] + move_delta({model_phase[i], cur},
							cfg_single);
						model_phase[i] = cur;
					end
				end
			end
			qcqd_pkg::OP_CAPTURE: begin
				model_sample = s.sample;
				for (int i = 0; i < n; i++)
					model_phase[i] = s.sample[2*i +: 2];
			end
			qcqd_pkg::OP_PRESET: model_count[s.chan] = s.preset;
			default: ;
		endcase
		for (int i = 0; i < 4; i++) begin
			r.count[i] = model_count[i];
			r.phase[i] = model_phase[i];
		end
		return r;
	endfunction

	function automatic stim_t row(input qcqd_pkg::op_t op, input logic [7:0] smp,
		input logic [1:0] ch, input logic [31:0] pv);
		stim_t s;
		s.op     = op;
		s.sample = smp;
		s.chan   = ch;
		s.preset = pv;
		s.typed  = 1'b0;
		s.want   = '0;
		return s;
	endfunction

	function automatic stim_t checked_row(input qcqd_pkg::op_t op, input logic [7:0] smp,
		input logic [1:0] ch, input logic [31:0] pv, input qcqd_pkg::result_t want);
		stim_t s;
		s = row(op, smp, ch, pv);
		s.typed = 1'b1;
		s.want  = want;
		return s;
	endfunction

	function automatic qcqd_pkg::result_t known(input bit chg,
		input logic [31:0] c0, c1, c2, c3, input logic [1:0] ph);
		qcqd_pkg::result_t r;
		r.changed  = chg;
		r.count[0] = c0;
		r.count[1] = c1;
		r.count[2] = c2;
		r.count[3] = c3;
		for (int i = 0; i < 4; i++)
			r.phase[i] = ph;
		return r;
	endfunction

	// mostly legal gray steps on the active lanes, the rest noise
	function automatic stim_t random_item();
		stim_t s;
		logic [1:0] ph;
		int pick;
		int r;
		int n;
		s = row(qcqd_pkg::OP_UPDATE, 8'($urandom), 2'($urandom), $urandom);
		n = active_lanes();
		pick = $urandom_range(99);
		if (pick < 72) begin
			for (int i = 0; i < n; i++) begin
				ph = model_phase[i];
				r = $urandom_range(99);
				if (r < 40)
					ph = {ph[0], ~ph[1]};
				else if (r < 75)
					ph = {~ph[0], ph[1]};
				else if (r >= 88)
					ph = ~ph;
				s.sample[2*i +: 2] = ph;
			end
		end else if (pick < 80) begin
			s.op = qcqd_pkg::OP_UPDATE;
		end else if (pick < 84) begin
			s.sample = model_sample;
		end else if (pick < 90) begin
			s.op = qcqd_pkg::OP_CAPTURE;
		end else if (pick < 97) begin
			s.op = qcqd_pkg::OP_PRESET;
			if ($urandom_range(3) == 0)
				s.preset = WRAP_VALUES[$urandom_range(3)] - $urandom_range(2);
		end else begin
			s.op = qcqd_pkg::OP_NONE;
		end
		return s;
	endfunction

	// offer one item, predict it once transferred
	task automatic put_item(input stim_t s);
		qcqd_pkg::result_t exp_res;
		while ($urandom_range(99) < send_idle_pct) begin
			samp_if.valid <= 1'b0;
			@(posedge clk);
		end
		samp_if.valid        <= 1'b1;
		samp_if.operation    <= s.op;
		samp_if.pin_sample   <= s.sample;
		samp_if.channel      <= s.chan;
		samp_if.preset_value <= s.preset;
		do @(posedge clk); while (!samp_if.ready);
		exp_res = decoder_step(s);
		if (s.typed)
			exp_res = s.want;
		pending_results.push_back(exp_res);
		items_sent++;
	endtask

	// stop offering until every expected result is back
	task automatic wait_drained();
		samp_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [qcqd_pkg::CFG_INDEX_W-1:0] idx,
		input logic [qcqd_pkg::CFG_DATA_W-1:0] val);
		cfg_if.valid     <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.data      <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == qcqd_pkg::REG_CHANNEL_COUNT)
			cfg_channels = val;
		else
			cfg_single = val[0];
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random stalls, one long hold-off on request, checking
	initial begin
		qcqd_pkg::result_t got;
		qcqd_pkg::result_t want;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.changed  = res_if.changed;
				got.count[0] = res_if.count_0;
				got.count[1] = res_if.count_1;
				got.count[2] = res_if.count_2;
				got.count[3] = res_if.count_3;
				got.phase[0] = res_if.phase_0;
				got.phase[1] = res_if.phase_1;
				got.phase[2] = res_if.phase_2;
				got.phase[3] = res_if.phase_3;
				results_seen++;
				if (pending_results.size() == 0) begin
					flag_error("result with nothing pending", got.count[0], 32'd0);
				end else begin
					want = pending_results.pop_front();
					if (got.changed !== want.changed)
						flag_error("changed", 32'(got.changed), 32'(want.changed));
					for (int i = 0; i < 4; i++) begin
						if (got.count[i] !== want.count[i])
							flag_error($sformatf("count_%0d", i), got.count[i], want.count[i]);
						if (got.phase[i] !== want.phase[i])
							flag_error($sformatf("phase_%0d", i), 32'(got.phase[i]),
								32'(want.phase[i]));
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// stimulus
	initial begin
		logic [1:0] mode_junk;
		arst_n               = 1'b0;
		samp_if.valid        = 1'b0;
		samp_if.operation    = qcqd_pkg::OP_UPDATE;
		samp_if.pin_sample   = '0;
		samp_if.channel      = '0;
		samp_if.preset_value = '0;
		res_if.ready         = 1'b0;
		cfg_if.valid         = 1'b0;
		cfg_if.reg_index     = qcqd_pkg::REG_CHANNEL_COUNT;
		cfg_if.data          = '0;
		cfg_channels         = qcqd_pkg::CHCNT_RESET;
		cfg_single           = 1'b0;
		model_sample         = '0;
		for (int i = 0; i < 4; i++) begin
			model_phase[i] = '0;
			model_count[i] = '0;
		end
		mismatch_count = 0;
		items_sent     = 0;
		results_seen   = 0;
		hold_request   = 1'b0;
		send_idle_pct  = 12;
		recv_idle_pct  = 75;

		// directed rows, reset settings: four lanes, up/down counting
		directed_rows.push_back(checked_row(qcqd_pkg::OP_UPDATE, 8'h00, 2'd0, 32'd0,
			known(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0)));
		directed_rows.push_back(checked_row(qcqd_pkg::OP_NONE, 8'hFF, 2'd3, 32'hFFFF_FFFF,
			known(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0)));
		directed_rows.push_back(checked_row(qcqd_pkg::OP_PRESET, 8'hFF, 2'd0, 32'h7FFF_FFFF,
			known(1'b0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 2'd0)));
		directed_rows.push_back(checked_row(qcqd_pkg::OP_PRESET, 8'h00, 2'd1, 32'h8000_0000,
			known(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 2'd0)));
		directed_rows.push_back(checked_row(qcqd_pkg::OP_PRESET, 8'h00, 2'd3, 32'hFFFF_FFFF,
			known(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 2'd0)));
		// first step up on every lane: lane 0 wraps from the signed maximum to the minimum, lane 3 from all ones to zero
		directed_rows.push_back(checked_row(qcqd_pkg::OP_UPDATE, 8'h55, 2'd0, 32'd0,
			known(1'b1, 32'h8000_0000, 32'h8000_0001, 32'd1, 32'd0, 2'd1)));
		// repeated sample, then the rest of the up cycle
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h55, 2'd2, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'hFF, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'hAA, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h00, 2'd0, 32'd0));
		// down cycle
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'hAA, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'hFF, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h55, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h00, 2'd0, 32'd0));
		// all four double jumps
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'hFF, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h00, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h55, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'hAA, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h55, 2'd0, 32'd0));
		// capture distinct phases, then move every lane differently
		directed_rows.push_back(row(qcqd_pkg::OP_CAPTURE, 8'hE4, 2'd1, 32'h5A5A_5A5A));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h1B, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_PRESET, 8'h00, 2'd2, 32'h1234_5678));
		// capture makes the next equal sample a no-change update
		directed_rows.push_back(row(qcqd_pkg::OP_CAPTURE, 8'h00, 2'd0, 32'd0));
		directed_rows.push_back(row(qcqd_pkg::OP_UPDATE, 8'h00, 2'd0, 32'd0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			put_item(directed_rows[i]);

		// random phases, one register setting each
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			repeat (3) @(posedge clk);
			if (p < 3) begin
				send_idle_pct = 12;
				recv_idle_pct = 75;
			end else if (p < 6) begin
				send_idle_pct = 75;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			mode_junk = 2'($urandom_range(3));
			write_reg(qcqd_pkg::REG_CHANNEL_COUNT, PHASE_CHANNELS[p]);
			write_reg(qcqd_pkg::REG_COUNT_MODE, {mode_junk, PHASE_SINGLE[p]});
			// long result stall while items keep coming, so the input backs up
			if (p == PRESSURE_PHASE)
				hold_request = 1'b1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k == ITEMS_PER_PHASE / 2)
					wait_drained();
				put_item(random_item());
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			flag_error("results never delivered", 32'(pending_results.size()), 32'd0);

		$display("%0d items in, %0d results compared; directed edge rows then %0d random phases",
			items_sent, results_seen, NUM_PHASES);
		$display("lane counts 0 to 7 in both counting modes, with stalls, hold-off and drains");
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
